// File: hw/rtl/lsrg_pkg.sv
// Shared types, codes and helper functions for the Laplacian stencil row generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lsrg_pkg;

	localparam int DIM_W      = 7;
	localparam int COORD_W    = 8;
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 14;
	localparam int OUT_IDX_W  = 12;
	localparam int COEF_W     = 3;
	localparam int N_ENT      = 5;
	localparam int ENT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [DIM_W-1:0]  WIDTH_RST  = 7'd64;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 7'd64;
	localparam logic [KIND_W-1:0] EDGE_RST   = 2'd1;

	localparam logic [KIND_W-1:0] KIND_NORMAL    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GRAD_HOLE = 2'd2;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_ROW = 1'b1;

	localparam logic signed [COEF_W-1:0] CENTRE_COEF = -3'sd4;
	localparam logic signed [COEF_W-1:0] DIAG_COEF   = 3'sd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH,
		CFG_GRID_HEIGHT,
		CFG_LEFT_EDGE,
		CFG_RIGHT_EDGE,
		CFG_TOP_EDGE,
		CFG_BOTTOM_EDGE
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_BUILD,
		ST_EMIT
	} state_t;

	typedef enum logic [ENT_W-1:0] {
		RD_CENTRE,
		RD_Y_PLUS,
		RD_Y_MINUS,
		RD_X_PLUS,
		RD_X_MINUS
	} rd_sel_t;

	typedef enum logic [1:0] {
		BUILD_ERR,
		BUILD_SET,
		BUILD_ROW
	} build_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             ep_left;
		logic             ep_right;
		logic             ep_top;
		logic             ep_bottom;
	} grid_cfg_t;

	typedef struct packed {
		logic             latch;
		logic             calc;
		logic             clr_wr;
		logic             mem_wr;
		logic             rd_en;
		rd_sel_t          rd_sel;
		logic             build;
		build_t           build_kind;
		logic             emit;
		logic [ENT_W-1:0] emit_idx;
		logic             emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic             in_grid;
		logic             op;
		logic             clr_last;
		logic             out_free;
		logic [ENT_W-1:0] n_ent;
	} dp_sts_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] cp;
		logic signed [COEF_W-1:0] cm;
	} pair_coef_t;

	function automatic pair_coef_t mirror(input logic [KIND_W-1:0] plus_kind,
			input logic [KIND_W-1:0] minus_kind);
		pair_coef_t r;
		r.cp = '0;
		r.cm = '0;
		if (plus_kind == KIND_NORMAL) begin
			r.cp = r.cp + 3'sd1;
		end else if (plus_kind == KIND_GRAD_HOLE) begin
			r.cm = r.cm + 3'sd1;
		end
		if (minus_kind == KIND_NORMAL) begin
			r.cm = r.cm + 3'sd1;
		end else if (minus_kind == KIND_GRAD_HOLE) begin
			r.cp = r.cp + 3'sd1;
		end
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] edge_coef(input logic ep);
		return ep ? 3'sd2 : 3'sd1;
	endfunction

endpackage

// File: hw/rtl/lsrg_if.sv
// Handshake channel interfaces: input items, result items and register writes.
// Depends on lsrg_pkg for field widths.
`timescale 1ns / 1ps

interface lsrg_item_if;
	import lsrg_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic signed [COORD_W-1:0] cell_row;
	logic signed [COORD_W-1:0] cell_col;
	logic [KIND_W-1:0]         cell_kind;
	modport source (output valid, operation, cell_row, cell_col, cell_kind, input ready);
	modport sink (input valid, operation, cell_row, cell_col, cell_kind, output ready);
endinterface

interface lsrg_result_if;
	import lsrg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OUT_IDX_W-1:0]     matrix_row;
	logic [OUT_IDX_W-1:0]     matrix_col;
	logic signed [COEF_W-1:0] coefficient;
	logic                     status;
	logic                     last;
	modport source (output valid, matrix_row, matrix_col, coefficient, status, last,
		input ready);
	modport sink (input valid, matrix_row, matrix_col, coefficient, status, last,
		output ready);
endinterface

interface lsrg_cfg_if;
	import lsrg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/laplacian_stencil_row_generator.sv
// Top level of the five-point Laplacian stencil row generator.
// Depends on lsrg_pkg, lsrg_if, lsrg_cfg, lsrg_dp and lsrg_ctrl.
//
//   channel  modport  transfer                                   payload
//   item     sink     one set or row request                     operation, cell_row,
//                                                                cell_col, cell_kind
//   result   source   one matrix entry, last marks the final one matrix_row, matrix_col,
//                                                                coefficient, status, last
//   cfg      sink     one register write, always ready           index, data
//
// A row item reads its five stencil cells from the type map in turn through the single
// read port; set and out-of-range items read none.
// After reset the map is cleared one cell a cycle, with item ready low; register writes
// are taken throughout.
// Results leave through a single output register; a stalled result holds the sequencer,
// while a new item may be taken as soon as the last entry of the previous one is loaded.
`timescale 1ns / 1ps

module laplacian_stencil_row_generator #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	lsrg_item_if.sink     item,
	lsrg_result_if.source result,
	lsrg_cfg_if.sink      cfg
);
	import lsrg_pkg::*;

	grid_cfg_t grid;
	dp_cmd_t   cmd;
	dp_sts_t   sts;

	assign cfg.ready = 1'b1;

	lsrg_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.grid     (grid)
	);

	lsrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsrg_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.grid        (grid),
		.operation   (item.operation),
		.cell_row    (item.cell_row),
		.cell_col    (item.cell_col),
		.cell_kind   (item.cell_kind),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.matrix_row  (result.matrix_row),
		.matrix_col  (result.matrix_col),
		.coefficient (result.coefficient),
		.status      (result.status),
		.last        (result.last)
	);

endmodule

// File: hw/rtl/lsrg_cfg.sv
// Configuration registers with grid size clamping and edge parameter decode.
// Depends on lsrg_pkg.
`timescale 1ns / 1ps

module lsrg_cfg #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [lsrg_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [lsrg_pkg::CFG_DATA_W-1:0] wr_data,
	output lsrg_pkg::grid_cfg_t            grid
);
	import lsrg_pkg::*;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [KIND_W-1:0] left_q;
	logic [KIND_W-1:0] right_q;
	logic [KIND_W-1:0] top_q;
	logic [KIND_W-1:0] bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			left_q   <= EDGE_RST;
			right_q  <= EDGE_RST;
			top_q    <= EDGE_RST;
			bottom_q <= EDGE_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_GRID_WIDTH:  width_q  <= wr_data;
				CFG_GRID_HEIGHT: height_q <= wr_data;
				CFG_LEFT_EDGE:   left_q   <= wr_data[KIND_W-1:0];
				CFG_RIGHT_EDGE:  right_q  <= wr_data[KIND_W-1:0];
				CFG_TOP_EDGE:    top_q    <= wr_data[KIND_W-1:0];
				CFG_BOTTOM_EDGE: bottom_q <= wr_data[KIND_W-1:0];
				default: ;
			endcase
		end
	end

	// Dirichlet bit wins over Neumann bit.
	always_comb begin
		if (width_q < DIM_W'(2)) begin
			grid.width = DIM_W'(2);
		end else if (width_q > MAX_WIDTH) begin
			grid.width = DIM_W'(MAX_WIDTH);
		end else begin
			grid.width = width_q;
		end
		if (height_q < DIM_W'(2)) begin
			grid.height = DIM_W'(2);
		end else if (height_q > MAX_HEIGHT) begin
			grid.height = DIM_W'(MAX_HEIGHT);
		end else begin
			grid.height = height_q;
		end
		grid.ep_left   = !left_q[0] && left_q[1];
		grid.ep_right  = !right_q[0] && right_q[1];
		grid.ep_top    = !top_q[0] && top_q[1];
		grid.ep_bottom = !bottom_q[0] && bottom_q[1];
	end

endmodule

// File: hw/rtl/lsrg_dp.sv
// Datapath: input latch, cell index, cell type memory, entry list and result register.
// Depends on lsrg_pkg; driven by lsrg_ctrl through dp_cmd_t / dp_sts_t.
`timescale 1ns / 1ps

module lsrg_dp #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lsrg_pkg::dp_cmd_t                    cmd,
	output lsrg_pkg::dp_sts_t                    sts,
	input  lsrg_pkg::grid_cfg_t                  grid,
	input  logic                                 operation,
	input  logic signed [lsrg_pkg::COORD_W-1:0]  cell_row,
	input  logic signed [lsrg_pkg::COORD_W-1:0]  cell_col,
	input  logic [lsrg_pkg::KIND_W-1:0]          cell_kind,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic [lsrg_pkg::OUT_IDX_W-1:0]       matrix_row,
	output logic [lsrg_pkg::OUT_IDX_W-1:0]       matrix_col,
	output logic signed [lsrg_pkg::COEF_W-1:0]   coefficient,
	output logic                                 status,
	output logic                                 last
);
	import lsrg_pkg::*;

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);

	logic                      op_q;
	logic signed [COORD_W-1:0] row_q;
	logic signed [COORD_W-1:0] col_q;
	logic [KIND_W-1:0]         kind_q;
	logic [IDX_W-1:0]          me_q;
	logic [IDX_W-1:0]          prod_c;

	logic [KIND_W-1:0] kind_mem [CELLS];
	logic [AW-1:0]     clr_addr_q;
	logic [AW-1:0]     wr_addr;
	logic [KIND_W-1:0] wr_data;
	logic              wr_en;
	logic [IDX_W-1:0]  rd_idx;
	logic [KIND_W-1:0] rdata_s1;
	logic              rd_en_s1;
	rd_sel_t           rd_sel_s1;
	logic [KIND_W-1:0] kinds_q [N_ENT];

	logic [IDX_W-1:0] me_yp, me_ym, me_xp, me_xm;
	logic             y_top, y_bot, x_left, x_right;
	logic             row_in, col_in;
	pair_coef_t       py_c, px_c;

	logic [OUT_IDX_W-1:0]     b_col  [N_ENT];
	logic signed [COEF_W-1:0] b_coef [N_ENT];
	logic [ENT_W-1:0]         b_n;
	logic [ENT_W-1:0]         b_p;

	logic [OUT_IDX_W-1:0]     ent_col_q  [N_ENT];
	logic signed [COEF_W-1:0] ent_coef_q [N_ENT];
	logic [ENT_W-1:0]         n_q;
	logic [OUT_IDX_W-1:0]     row_idx_q;
	logic                     status_q;
	logic                     res_valid_q;

	// Input latch and cell index.
	assign prod_c = IDX_W'(row_q[COORD_W-2:0]) * IDX_W'(grid.width);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= operation;
			row_q  <= cell_row;
			col_q  <= cell_col;
			kind_q <= cell_kind;
		end
		if (cmd.calc) begin
			me_q <= prod_c + IDX_W'(col_q[COORD_W-2:0]);
		end
	end

	assign row_in  = !row_q[COORD_W-1] && (row_q[COORD_W-2:0] < grid.height);
	assign col_in  = !col_q[COORD_W-1] && (col_q[COORD_W-2:0] < grid.width);
	assign y_top   = row_q[COORD_W-2:0] == '0;
	assign y_bot   = row_q[COORD_W-2:0] == grid.height - DIM_W'(1);
	assign x_left  = col_q[COORD_W-2:0] == '0;
	assign x_right = col_q[COORD_W-2:0] == grid.width - DIM_W'(1);

	assign me_yp = me_q + IDX_W'(grid.width);
	assign me_ym = me_q - IDX_W'(grid.width);
	assign me_xp = me_q + IDX_W'(1);
	assign me_xm = me_q - IDX_W'(1);

	// Cell type memory: one write port shared with the clearing sweep, one read port.
	assign wr_en   = cmd.clr_wr || cmd.mem_wr;
	assign wr_addr = cmd.clr_wr ? clr_addr_q : AW'(me_q);
	assign wr_data = cmd.clr_wr ? KIND_NORMAL : kind_q;

	always_comb begin
		case (cmd.rd_sel)
			RD_CENTRE:  rd_idx = me_q;
			RD_Y_PLUS:  rd_idx = me_yp;
			RD_Y_MINUS: rd_idx = me_ym;
			RD_X_PLUS:  rd_idx = me_xp;
			RD_X_MINUS: rd_idx = me_xm;
			default:    rd_idx = me_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			kind_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= kind_mem[AW'(rd_idx)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			rd_en_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_sel_s1 <= cmd.rd_sel;
		if (rd_en_s1) begin
			kinds_q[rd_sel_s1] <= rdata_s1;
		end
	end

	// Entry list: y neighbors, x neighbors, then the centre; a non-normal cell gets only its diagonal entry.
	assign py_c = mirror(kinds_q[RD_Y_PLUS], kinds_q[RD_Y_MINUS]);
	assign px_c = mirror(kinds_q[RD_X_PLUS], kinds_q[RD_X_MINUS]);

	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			b_col[i]  = '0;
			b_coef[i] = '0;
		end
		b_n = ENT_W'(1);
		b_p = '0;
		if (cmd.build_kind == BUILD_ROW) begin
			if (kinds_q[RD_CENTRE] != KIND_NORMAL) begin
				b_col[0]  = me_q[OUT_IDX_W-1:0];
				b_coef[0] = DIAG_COEF;
			end else begin
				if (y_top) begin
					b_col[b_p]  = me_yp[OUT_IDX_W-1:0];
					b_coef[b_p] = edge_coef(grid.ep_top);
					b_p         = b_p + ENT_W'(1);
				end else if (y_bot) begin
					b_col[b_p]  = me_ym[OUT_IDX_W-1:0];
					b_coef[b_p] = edge_coef(grid.ep_bottom);
					b_p         = b_p + ENT_W'(1);
				end else begin
					b_col[b_p]  = me_yp[OUT_IDX_W-1:0];
					b_coef[b_p] = py_c.cp;
					b_p         = b_p + ENT_W'(1);
					b_col[b_p]  = me_ym[OUT_IDX_W-1:0];
					b_coef[b_p] = py_c.cm;
					b_p         = b_p + ENT_W'(1);
				end
				if (x_left) begin
					b_col[b_p]  = me_xp[OUT_IDX_W-1:0];
					b_coef[b_p] = edge_coef(grid.ep_left);
					b_p         = b_p + ENT_W'(1);
				end else if (x_right) begin
					b_col[b_p]  = me_xm[OUT_IDX_W-1:0];
					b_coef[b_p] = edge_coef(grid.ep_right);
					b_p         = b_p + ENT_W'(1);
				end else begin
					b_col[b_p]  = me_xp[OUT_IDX_W-1:0];
					b_coef[b_p] = px_c.cp;
					b_p         = b_p + ENT_W'(1);
					b_col[b_p]  = me_xm[OUT_IDX_W-1:0];
					b_coef[b_p] = px_c.cm;
					b_p         = b_p + ENT_W'(1);
				end
				b_col[b_p]  = me_q[OUT_IDX_W-1:0];
				b_coef[b_p] = CENTRE_COEF;
				b_n         = b_p + ENT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build) begin
			for (int i = 0; i < N_ENT; i++) begin
				ent_col_q[i]  <= b_col[i];
				ent_coef_q[i] <= b_coef[i];
			end
			n_q       <= b_n;
			status_q  <= cmd.build_kind == BUILD_ERR;
			row_idx_q <= (cmd.build_kind == BUILD_ROW) ? me_q[OUT_IDX_W-1:0] : '0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			matrix_row  <= row_idx_q;
			matrix_col  <= ent_col_q[cmd.emit_idx];
			coefficient <= ent_coef_q[cmd.emit_idx];
			status      <= status_q;
			last        <= cmd.emit_last;
		end
	end

	assign res_valid = res_valid_q;

	assign sts.in_grid  = row_in && col_in;
	assign sts.op       = op_q;
	assign sts.clr_last = clr_addr_q == AW'(CELLS - 1);
	assign sts.out_free = !res_valid_q || res_ready;
	assign sts.n_ent    = n_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!res_valid_q || res_ready))
		else $error("entry loaded over a pending result");

	a_wr_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (sts.in_grid && op_q == OP_SET && me_q < CELLS))
		else $error("map write outside the grid");

	a_clr_alone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> (!cmd.mem_wr && !cmd.latch && !cmd.rd_en))
		else $error("map access during clearing sweep");

endmodule

// File: hw/rtl/lsrg_ctrl.sv
// Controller state machine: clearing sweep, item sequencing and entry emission.
// Depends on lsrg_pkg; commands lsrg_dp through dp_cmd_t / dp_sts_t.
`timescale 1ns / 1ps

module lsrg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsrg_pkg::dp_sts_t sts,
	output lsrg_pkg::dp_cmd_t cmd
);
	import lsrg_pkg::*;

	state_t           state_q, state_d;
	logic [ENT_W-1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				k_d      = '0;
				if (!sts.in_grid) begin
					cmd.build      = 1'b1;
					cmd.build_kind = BUILD_ERR;
					state_d        = ST_EMIT;
				end else if (sts.op == OP_SET) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_WRITE: begin
				cmd.mem_wr     = 1'b1;
				cmd.build      = 1'b1;
				cmd.build_kind = BUILD_SET;
				state_d        = ST_EMIT;
			end
			ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rd_sel_t'(k_q);
				if (k_q == RD_X_MINUS) begin
					k_d     = '0;
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + ENT_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_BUILD;
			end
			ST_BUILD: begin
				cmd.build      = 1'b1;
				cmd.build_kind = BUILD_ROW;
				k_d            = '0;
				state_d        = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_idx  = k_q;
					cmd.emit_last = k_q == sts.n_ent - ENT_W'(1);
					if (cmd.emit_last) begin
						k_d     = '0;
						state_d = ST_IDLE;
					end else begin
						k_d = k_q + ENT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q < sts.n_ent))
		else $error("entry index past the entry count");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> (state_q == ST_IDLE))
		else $error("final entry not followed by idle");

	a_latch_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == ST_CALC))
		else $error("accepted item not followed by index calculation");

endmodule

// File: sim/laplacian_stencil_row_generator_tb.sv
// Self-checking testbench for the five-point Laplacian stencil row generator.
// Drives set and row requests; predicts matrix entries in a local model of the type map
// and grid registers or takes typed ones from its table; depends on lsrg_pkg, lsrg_if and the RTL top.
`timescale 1ns / 1ps

module laplacian_stencil_row_generator_tb;
	import lsrg_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int CELLS = MAX_W * MAX_H;
	localparam int N_SETTINGS = 9;
	localparam int ITEMS_PER_SETTING = 45;
	localparam int SETTLE_CYCLES = 30;
	localparam int N_DIRECTED = 25;

	localparam logic [KIND_W-1:0] KIND_VALUE_HOLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SPARE      = 2'd3;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;
	localparam logic TYPED        = 1'b1;
	localparam logic PREDICTED    = 1'b0;

	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
		logic [KIND_W-1:0]         kind;
	} item_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0]     row_idx;
		logic [OUT_IDX_W-1:0]     col_idx;
		logic signed [COEF_W-1:0] coef;
		logic                     status;
		logic                     last;
	} entry_t;

	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
		logic [KIND_W-1:0]         kind;
		logic                      typed;
		logic [OUT_IDX_W-1:0]      row_idx;
		logic [OUT_IDX_W-1:0]      col_idx;
		logic signed [COEF_W-1:0]  coef;
		logic                      status;
	} directed_row_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [KIND_W-1:0] left;
		logic [KIND_W-1:0] right;
		logic [KIND_W-1:0] top;
		logic [KIND_W-1:0] bottom;
	} grid_setting_t;

	logic clk;
	logic arst_n;

	lsrg_item_if   item_ch ();
	lsrg_result_if result_ch ();
	lsrg_cfg_if    cfg_ch ();

	laplacian_stencil_row_generator #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	logic [KIND_W-1:0] kind_map [CELLS];
	logic [DIM_W-1:0]  cfg_width;
	logic [DIM_W-1:0]  cfg_height;
	logic [KIND_W-1:0] cfg_left;
	logic [KIND_W-1:0] cfg_right;
	logic [KIND_W-1:0] cfg_top;
	logic [KIND_W-1:0] cfg_bottom;

	entry_t pending_entries [$];

	int err_count       = 0;
	int items_sent      = 0;
	int entries_checked = 0;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int focus_y         = 0;
	int focus_x         = 0;

	directed_row_t directed_tab [N_DIRECTED] = '{
		'{OP_ROW, 8'sd0, 8'sd0, KIND_NORMAL, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd63, 8'sd63, KIND_SPARE, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd30, 8'sd0, KIND_NORMAL, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd0, 8'sd30, KIND_VALUE_HOLE, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd63, 8'sd30, KIND_GRAD_HOLE, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_SET, -8'sd1, 8'sd5, KIND_VALUE_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_RANGE},
		'{OP_SET, 8'sd64, 8'sd0, KIND_GRAD_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_RANGE},
		'{OP_ROW, 8'sd5, -8'sd1, KIND_NORMAL, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_RANGE},
		'{OP_ROW, 8'sd0, 8'sd64, KIND_NORMAL, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_RANGE},
		'{OP_ROW, 8'h80, 8'sd127, KIND_SPARE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_RANGE},
		'{OP_SET, 8'sd127, 8'h80, KIND_SPARE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_RANGE},
		'{OP_SET, 8'sd10, 8'sd10, KIND_VALUE_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd10, 8'sd10, KIND_NORMAL, TYPED, 12'd650, 12'd650, DIAG_COEF, STATUS_OK},
		'{OP_SET, 8'sd10, 8'sd12, KIND_GRAD_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd10, 8'sd11, KIND_NORMAL, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_SET, 8'sd9, 8'sd11, KIND_SPARE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd9, 8'sd11, KIND_NORMAL, TYPED, 12'd587, 12'd587, DIAG_COEF, STATUS_OK},
		'{OP_SET, 8'sd12, 8'sd11, KIND_GRAD_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd11, 8'sd11, KIND_NORMAL, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_SET, 8'sd1, 8'sd30, KIND_VALUE_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd0, 8'sd30, KIND_NORMAL, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_SET, 8'sd63, 8'sd63, KIND_GRAD_HOLE, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd63, 8'sd63, KIND_NORMAL, TYPED, 12'd4095, 12'd4095, DIAG_COEF,
			STATUS_OK},
		'{OP_SET, 8'sd10, 8'sd10, KIND_NORMAL, TYPED, 12'd0, 12'd0, 3'sd0, STATUS_OK},
		'{OP_ROW, 8'sd10, 8'sd10, KIND_VALUE_HOLE, PREDICTED, 12'd0, 12'd0, 3'sd0, STATUS_OK}
	};

	grid_setting_t grid_settings [N_SETTINGS] = '{
		'{7'd4,   7'd4,   2'd0, 2'd1, 2'd2, 2'd3},
		'{7'd2,   7'd2,   2'd2, 2'd2, 2'd2, 2'd2},
		'{7'd64,  7'd2,   2'd3, 2'd0, 2'd1, 2'd2},
		'{7'd0,   7'd127, 2'd1, 2'd2, 2'd3, 2'd0},
		'{7'd7,   7'd5,   2'd2, 2'd3, 2'd0, 2'd1},
		'{7'd65,  7'd1,   2'd0, 2'd2, 2'd2, 2'd3},
		'{7'd3,   7'd64,  2'd2, 2'd2, 2'd0, 2'd0},
		'{7'd64,  7'd64,  2'd2, 2'd2, 2'd2, 2'd2},
		'{7'd6,   7'd9,   2'd0, 2'd3, 2'd2, 2'd1}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic int edge_bonus(input logic [KIND_W-1:0] k);
		if (k[0]) return 0;
		if (k[1]) return 1;
		return 0;
	endfunction

	function automatic int clamp_to(input int v, input int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic entry_t make_entry(input int row, input int col, input int coef,
			input logic status);
		entry_t e;
		e.row_idx = OUT_IDX_W'(row);
		e.col_idx = OUT_IDX_W'(col);
		e.coef    = COEF_W'(coef);
		e.status  = status;
		e.last    = 1'b0;
		return e;
	endfunction

	// Weights of two opposite inner neighbors, plus side first.
	function automatic void pair_weights(input logic [KIND_W-1:0] plus_kind,
			input logic [KIND_W-1:0] minus_kind, output int cp, output int cm);
		cp = 0;
		cm = 0;
		if (plus_kind == KIND_NORMAL) cp++;
		else if (plus_kind == KIND_GRAD_HOLE) cm++;
		if (minus_kind == KIND_NORMAL) cm++;
		else if (minus_kind == KIND_GRAD_HOLE) cp++;
	endfunction

	function automatic int stencil_entries(input item_t it, output entry_t ents [N_ENT]);
		int w;
		int h;
		int y;
		int x;
		int me;
		int n;
		int cp;
		int cm;
		w = eff_dim(cfg_width, MAX_W);
		h = eff_dim(cfg_height, MAX_H);
		y = $signed(it.y);
		x = $signed(it.x);
		for (n = 0; n < N_ENT; n++) ents[n] = '0;
		n = 0;
		if (!(y >= 0 && y < h && x >= 0 && x < w)) begin
			ents[0] = make_entry(0, 0, 0, STATUS_RANGE);
			ents[0].last = 1'b1;
			return 1;
		end
		me = y * w + x;
		if (it.op == OP_SET) begin
			kind_map[me] = it.kind;
			ents[0] = make_entry(0, 0, 0, STATUS_OK);
			ents[0].last = 1'b1;
			return 1;
		end
		if (kind_map[me] != KIND_NORMAL) begin
			ents[0] = make_entry(me, me, DIAG_COEF, STATUS_OK);
			ents[0].last = 1'b1;
			return 1;
		end
		if (y == 0) begin
			ents[n] = make_entry(me, me + w, 1 + edge_bonus(cfg_top), STATUS_OK);
			n = n + 1;
		end else if (y == h - 1) begin
			ents[n] = make_entry(me, me - w, 1 + edge_bonus(cfg_bottom), STATUS_OK);
			n = n + 1;
		end else begin
			pair_weights(kind_map[me + w], kind_map[me - w], cp, cm);
			ents[n] = make_entry(me, me + w, cp, STATUS_OK);
			n = n + 1;
			ents[n] = make_entry(me, me - w, cm, STATUS_OK);
			n = n + 1;
		end
		if (x == 0) begin
			ents[n] = make_entry(me, me + 1, 1 + edge_bonus(cfg_left), STATUS_OK);
			n = n + 1;
		end else if (x == w - 1) begin
			ents[n] = make_entry(me, me - 1, 1 + edge_bonus(cfg_right), STATUS_OK);
			n = n + 1;
		end else begin
			pair_weights(kind_map[me + 1], kind_map[me - 1], cp, cm);
			ents[n] = make_entry(me, me + 1, cp, STATUS_OK);
			n = n + 1;
			ents[n] = make_entry(me, me - 1, cm, STATUS_OK);
			n = n + 1;
		end
		ents[n] = make_entry(me, me, CENTRE_COEF, STATUS_OK);
		n = n + 1;
		ents[n-1].last = 1'b1;
		return n;
	endfunction

	// Mostly requests clustered around a moving focus cell, some just off the grid,
	// some raw noise.
	function automatic item_t random_item();
		item_t it;
		int w;
		int h;
		int r;
		int k;
		w = eff_dim(cfg_width, MAX_W);
		h = eff_dim(cfg_height, MAX_H);
		r = $urandom_range(99);
		it.op = 1'($urandom_range(1));
		it.kind = KIND_W'($urandom_range(3));
		if (r < 8) begin
			it.y = COORD_W'($urandom);
			it.x = COORD_W'($urandom);
		end else if (r < 15) begin
			it.y = COORD_W'($urandom_range(h - 1));
			it.x = COORD_W'($urandom_range(w - 1));
			case ($urandom_range(3))
				0: it.y = COORD_W'(-1);
				1: it.y = COORD_W'(h);
				2: it.x = COORD_W'(-1);
				default: it.x = COORD_W'(w);
			endcase
		end else begin
			if ($urandom_range(4) == 0) begin
				focus_y = $urandom_range(h - 1);
				focus_x = $urandom_range(w - 1);
			end
			focus_y = clamp_to(focus_y, h - 1);
			focus_x = clamp_to(focus_x, w - 1);
			it.y = COORD_W'(clamp_to(focus_y + int'($urandom_range(2)) - 1, h - 1));
			it.x = COORD_W'(clamp_to(focus_x + int'($urandom_range(2)) - 1, w - 1));
			it.op = ($urandom_range(99) < 35) ? OP_SET : OP_ROW;
			if (it.op == OP_SET) begin
				k = $urandom_range(9);
				it.kind = (k < 4) ? KIND_NORMAL : KIND_W'((k - 4) % 3 + 1);
			end
		end
		return it;
	endfunction

	task automatic report(input string what);
		err_count++;
		$display("%0t ERROR %s", $time, what);
	endtask

	task automatic queue_entry(input entry_t e);
		pending_entries = {pending_entries, e};
	endtask

	task automatic send_item(input item_t it, input logic typed, input entry_t want);
		entry_t ents [N_ENT];
		int n;
		int i;
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.operation <= it.op;
		item_ch.cell_row  <= it.y;
		item_ch.cell_col  <= it.x;
		item_ch.cell_kind <= it.kind;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		n = stencil_entries(it, ents);
		if (typed) begin
			queue_entry(want);
		end else begin
			for (i = 0; i < n; i++) queue_entry(ents[i]);
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_GRID_WIDTH:  cfg_width  = value;
			CFG_GRID_HEIGHT: cfg_height = value;
			CFG_LEFT_EDGE:   cfg_left   = value[KIND_W-1:0];
			CFG_RIGHT_EDGE:  cfg_right  = value[KIND_W-1:0];
			CFG_TOP_EDGE:    cfg_top    = value[KIND_W-1:0];
			CFG_BOTTOM_EDGE: cfg_bottom = value[KIND_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain_and_settle();
		item_ch.valid <= 1'b0;
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		entry_t want;
		if (result_ch.valid && result_ch.ready) begin
			entries_checked++;
			if (pending_entries.size() == 0) begin
				report($sformatf("unexpected entry row %0d col %0d",
					result_ch.matrix_row, result_ch.matrix_col));
			end else begin
				want = pending_entries.pop_front();
				if (result_ch.matrix_row !== want.row_idx)
					report($sformatf("matrix_row got %0d want %0d",
						result_ch.matrix_row, want.row_idx));
				if (result_ch.matrix_col !== want.col_idx)
					report($sformatf("matrix_col got %0d want %0d",
						result_ch.matrix_col, want.col_idx));
				if (result_ch.coefficient !== want.coef)
					report($sformatf("coefficient got %0d want %0d (row %0d col %0d)",
						result_ch.coefficient, want.coef, want.row_idx, want.col_idx));
				if (result_ch.status !== want.status)
					report($sformatf("status got %0b want %0b",
						result_ch.status, want.status));
				if (result_ch.last !== want.last)
					report($sformatf("last got %0b want %0b (row %0d col %0d)",
						result_ch.last, want.last, want.row_idx, want.col_idx));
			end
		end
	end

	initial begin
		grid_setting_t s;
		directed_row_t d;
		item_t it;
		entry_t want;
		int b;
		int i;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_SET;
		item_ch.cell_row = '0;
		item_ch.cell_col = '0;
		item_ch.cell_kind = KIND_NORMAL;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_GRID_WIDTH;
		cfg_ch.data = '0;
		cfg_width = WIDTH_RST;
		cfg_height = HEIGHT_RST;
		cfg_left = EDGE_RST;
		cfg_right = EDGE_RST;
		cfg_top = EDGE_RST;
		cfg_bottom = EDGE_RST;
		foreach (kind_map[j]) kind_map[j] = KIND_NORMAL;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 38;
		recv_idle_pct = 59;
		for (i = 0; i < N_DIRECTED; i++) begin
			d = directed_tab[i];
			it = '{d.op, d.y, d.x, d.kind};
			want = '{d.row_idx, d.col_idx, d.coef, d.status, 1'b1};
			send_item(it, d.typed, want);
		end
		drain_and_settle();

		for (b = 0; b < N_SETTINGS; b++) begin
			send_idle_pct = (b < 3) ? 38 : (b < 6) ? 59 : 0;
			recv_idle_pct = (b < 3) ? 59 : (b < 6) ? 38 : 0;
			s = grid_settings[b];
			write_reg(CFG_GRID_WIDTH, s.width);
			write_reg(CFG_GRID_HEIGHT, s.height);
			write_reg(CFG_LEFT_EDGE, {5'($urandom), s.left});
			write_reg(CFG_RIGHT_EDGE, {5'($urandom), s.right});
			write_reg(CFG_TOP_EDGE, {5'($urandom), s.top});
			write_reg(CFG_BOTTOM_EDGE, {5'($urandom), s.bottom});
			cfg_ch.valid <= 1'b0;
			repeat (ITEMS_PER_SETTING) send_item(random_item(), PREDICTED, '0);
			drain_and_settle();
		end

		$display("covered %0d requests (%0d directed) over %0d grid settings, %0d entries",
			items_sent, N_DIRECTED, N_SETTINGS, entries_checked);
		$display("sender and receiver idled at 38/59 percent, then 59/38, then not at all");
		if (err_count == 0) begin
			$display("laplacian_stencil_row_generator: match");
		end else begin
			$display("laplacian_stencil_row_generator: mismatch");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("laplacian_stencil_row_generator: mismatch");
		$finish;
	end

endmodule
